/* sv/sbpcm_pkg.sv */
// ----------------------------------------------------------------------------
// sbpcm_pkg
// Shared types, register indexes and step tables for the sample body decoder.
// ----------------------------------------------------------------------------
package sbpcm_pkg;

    localparam int COUNT_BITS = 24;
    localparam int MODE_BITS  = 3;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_BITS   = $clog2(FIFO_DEPTH);

    typedef enum logic [MODE_BITS-1:0] {
        MODE_PCM8      = 3'd0,
        MODE_PCM16_BE  = 3'd1,
        MODE_PCM16_LE  = 3'd2,
        MODE_DELTA_FIB = 3'd3,
        MODE_DELTA_EXP = 3'd4
    } mode_t;

    // configuration register indexes
    localparam logic REG_CODING_MODE  = 1'b0;
    localparam logic REG_SAMPLE_TOTAL = 1'b1;

    // byte position within header or pcm16 pair
    localparam logic [1:0] PHASE_FIRST  = 2'd0;
    localparam logic [1:0] PHASE_SECOND = 2'd1;
    localparam logic [1:0] PHASE_DATA   = 2'd2;

    typedef struct packed {
        logic [1:0]            phase;
        logic [7:0]            held;
        logic [7:0]            acc;
        logic [COUNT_BITS-1:0] emitted;
    } state_t;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last;
        logic               done;
    } result_t;

    typedef struct packed {
        logic [1:0] n_res;
        result_t    res0;
        result_t    res1;
        state_t     state;
    } dec_out_t;

    function automatic logic signed [7:0] fib_step(input logic [3:0] nib);
        logic signed [7:0] s;
        case (nib)
            4'd0:    s = -8'sd34;
            4'd1:    s = -8'sd21;
            4'd2:    s = -8'sd13;
            4'd3:    s = -8'sd8;
            4'd4:    s = -8'sd5;
            4'd5:    s = -8'sd3;
            4'd6:    s = -8'sd2;
            4'd7:    s = -8'sd1;
            4'd8:    s = 8'sd0;
            4'd9:    s = 8'sd1;
            4'd10:   s = 8'sd2;
            4'd11:   s = 8'sd3;
            4'd12:   s = 8'sd5;
            4'd13:   s = 8'sd8;
            4'd14:   s = 8'sd13;
            default: s = 8'sd21;
        endcase
        return s;
    endfunction

    function automatic logic signed [7:0] exp_step(input logic [3:0] nib);
        logic signed [7:0] s;
        case (nib)
            4'd0:    s = -8'sd128;
            4'd1:    s = -8'sd64;
            4'd2:    s = -8'sd32;
            4'd3:    s = -8'sd16;
            4'd4:    s = -8'sd8;
            4'd5:    s = -8'sd4;
            4'd6:    s = -8'sd2;
            4'd7:    s = -8'sd1;
            4'd8:    s = 8'sd0;
            4'd9:    s = 8'sd1;
            4'd10:   s = 8'sd2;
            4'd11:   s = 8'sd4;
            4'd12:   s = 8'sd8;
            4'd13:   s = 8'sd16;
            4'd14:   s = 8'sd32;
            default: s = 8'sd64;
        endcase
        return s;
    endfunction

endpackage

/* sv/sbpcm_decode.sv */
// ----------------------------------------------------------------------------
// sbpcm_decode
// Next state and up to two samples for one body byte.
// ----------------------------------------------------------------------------
module sbpcm_decode
(
    input  logic [7:0]                      body_byte,
    input  logic                            restart,
    input  logic [sbpcm_pkg::MODE_BITS-1:0] coding_mode,
    input  logic [sbpcm_pkg::COUNT_BITS-1:0] sample_total,
    input  sbpcm_pkg::state_t               state_cur,
    output sbpcm_pkg::dec_out_t             dec
);
    import sbpcm_pkg::*;

    function automatic logic [7:0] sat_add(input logic [7:0] acc, input logic [7:0] step);
        logic signed [8:0] sum;
        logic [7:0]        r;
        sum = $signed({acc[7], acc}) + $signed({step[7], step});
        if (sum > 9'sd127)
            r = 8'h7f;
        else if (sum < -9'sd128)
            r = 8'h80;
        else
            r = sum[7:0];
        return r;
    endfunction

    state_t                st;
    logic                  finished;
    logic [COUNT_BITS-1:0] cnt1;
    logic [COUNT_BITS-1:0] cnt2;
    logic                  done1;
    logic                  done2;
    logic                  is_fib;
    logic [7:0]            step_hi;
    logic [7:0]            step_lo;
    logic [7:0]            acc1;
    logic [7:0]            acc2;

    always_comb
    begin
        st = state_cur;
        if (restart)
        begin
            st = '0;
        end
        finished = (st.emitted >= sample_total);
        cnt1     = st.emitted + COUNT_BITS'(1);
        cnt2     = st.emitted + COUNT_BITS'(2);
        done1    = (cnt1 >= sample_total);
        done2    = (cnt2 >= sample_total);
        is_fib   = (coding_mode == MODE_DELTA_FIB);
        step_hi  = is_fib ? fib_step(body_byte[7:4]) : exp_step(body_byte[7:4]);
        step_lo  = is_fib ? fib_step(body_byte[3:0]) : exp_step(body_byte[3:0]);
        acc1     = sat_add(st.acc, step_hi);
        acc2     = sat_add(acc1, step_lo);

        dec       = '0;
        dec.state = st;
        if (!finished)
        begin
            case (coding_mode)
                MODE_PCM8:
                begin
                    dec.n_res         = 2'd1;
                    dec.res0.sample   = {body_byte, 8'h00};
                    dec.res0.last     = 1'b1;
                    dec.res0.done     = done1;
                    dec.state.emitted = cnt1;
                end
                MODE_PCM16_BE, MODE_PCM16_LE:
                begin
                    if (st.phase == PHASE_FIRST)
                    begin
                        dec.state.held  = body_byte;
                        dec.state.phase = PHASE_SECOND;
                    end
                    else
                    begin
                        dec.n_res         = 2'd1;
                        dec.res0.sample   = (coding_mode == MODE_PCM16_BE)
                                            ? {st.held, body_byte}
                                            : {body_byte, st.held};
                        dec.res0.last     = 1'b1;
                        dec.res0.done     = done1;
                        dec.state.phase   = PHASE_FIRST;
                        dec.state.emitted = cnt1;
                    end
                end
                MODE_DELTA_FIB, MODE_DELTA_EXP:
                begin
                    if (st.phase == PHASE_FIRST)
                    begin
                        // padding byte
                        dec.state.phase = PHASE_SECOND;
                    end
                    else if (st.phase == PHASE_SECOND)
                    begin
                        dec.state.acc   = body_byte;
                        dec.state.phase = PHASE_DATA;
                    end
                    else
                    begin
                        dec.res0.sample = {acc1, 8'h00};
                        dec.res0.done   = done1;
                        dec.res1.sample = {acc2, 8'h00};
                        dec.res1.last   = 1'b1;
                        dec.res1.done   = done2;
                        if (done1)
                        begin
                            // total reached on the high nibble
                            dec.n_res         = 2'd1;
                            dec.res0.last     = 1'b1;
                            dec.state.acc     = acc1;
                            dec.state.emitted = cnt1;
                        end
                        else
                        begin
                            dec.n_res         = 2'd2;
                            dec.state.acc     = acc2;
                            dec.state.emitted = cnt2;
                        end
                    end
                end
                default:
                begin
                    dec.n_res = 2'd0;
                end
            endcase
        end
    end

endmodule

/* sv/sbpcm_fifo.sv */
// ----------------------------------------------------------------------------
// sbpcm_fifo
// Four-entry result queue taking up to two results per cycle, giving one while pop_ready is high.
// ----------------------------------------------------------------------------
module sbpcm_fifo
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          push_n,
    input  sbpcm_pkg::result_t  push0,
    input  sbpcm_pkg::result_t  push1,
    output logic                room,
    output logic                pop_valid,
    input  logic                pop_ready,
    output sbpcm_pkg::result_t  pop_data
);
    import sbpcm_pkg::*;

    result_t               mem [FIFO_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg;
    logic [PTR_BITS-1:0]   wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg;
    logic [PTR_BITS-1:0]   rd_ptr_next;
    logic [PTR_BITS:0]     count_reg;
    logic [PTR_BITS:0]     count_next;
    logic                  pop;

    assign pop       = pop_valid && pop_ready;
    assign pop_valid = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];
    // room for a full pair
    assign room      = (count_reg <= (PTR_BITS+1)'(FIFO_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_BITS'(push_n);
        rd_ptr_next = rd_ptr_reg + PTR_BITS'(pop);
        count_next  = count_reg + (PTR_BITS+1)'(push_n) - (PTR_BITS+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            mem[wr_ptr_reg] <= push0;
        end
        if (push_n == 2'd2)
        begin
            mem[wr_ptr_reg + PTR_BITS'(1)] <= push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* sv/sample_body_to_pcm16_unit.sv */
// ----------------------------------------------------------------------------
// sample_body_to_pcm16_unit
// Decodes sample body bytes (pcm8, pcm16 be/le, fibonacci/exponential delta)
// into signed 16-bit samples with a per-body sample limit.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                    tuser           tlast
//  s_*      in   [7:0] body_byte          restart         -
//  m_*      out  [15:0] sample_value      body_done       run_last
//  cfg_*    in   index 0 coding_mode, index 1 sample_total (no read-back)
//
//  a byte is decoded in the cycle it is accepted; its samples appear on m_*
//  from the next cycle, one beat per cycle while m_tready is high, from a
//  four-entry result queue; s_tready is high while it has room for two
//  results, so pcm bytes then flow one per cycle; delta data bytes push two
//  results each and stall. reset clears mode, total, decoder state and queue.
// ----------------------------------------------------------------------------
module sample_body_to_pcm16_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // body_byte
    input  logic                              s_tuser,   // restart
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [15:0]                       m_tdata,   // sample_value
    output logic                              m_tuser,   // body_done
    output logic                              m_tlast,   // run_last
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [sbpcm_pkg::COUNT_BITS-1:0]  cfg_data
);
    import sbpcm_pkg::*;

    logic [MODE_BITS-1:0]  mode_reg;
    logic [COUNT_BITS-1:0] total_reg;
    state_t                state_reg;
    dec_out_t              dec;
    logic                  accept;
    logic [1:0]            push_n;
    result_t               out_res;

    assign accept = s_tvalid && s_tready;
    assign push_n = accept ? dec.n_res : 2'd0;

    sbpcm_decode u_decode
    (
        .body_byte    (s_tdata),
        .restart      (s_tuser),
        .coding_mode  (mode_reg),
        .sample_total (total_reg),
        .state_cur    (state_reg),
        .dec          (dec)
    );

    sbpcm_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_n    (push_n),
        .push0     (dec.res0),
        .push1     (dec.res1),
        .room      (s_tready),
        .pop_valid (m_tvalid),
        .pop_ready (m_tready),
        .pop_data  (out_res)
    );

    assign m_tdata = out_res.sample;
    assign m_tlast = out_res.last;
    assign m_tuser = out_res.done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= '0;
            total_reg <= '0;
            state_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CODING_MODE:  mode_reg  <= cfg_data[MODE_BITS-1:0];
                    REG_SAMPLE_TOTAL: total_reg <= cfg_data;
                    default:          mode_reg  <= mode_reg;
                endcase
            end
            if (accept)
            begin
                state_reg <= dec.state;
            end
        end
    end

endmodule
